// File: hw/rtl/rta_pkg.sv
`default_nettype none
package rta_pkg;

   // Number format: signed Q8.24 words, CORDIC datapath with guard bits
   localparam int WORD_W       = 32;
   localparam int FRAC_W       = 24;
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_W     = 40;
   localparam int PROD_W       = 2 * WORD_W;

   typedef logic signed [WORD_W-1:0]   word_type;
   typedef logic signed [CORDIC_W-1:0] cord_type;
   typedef logic signed [PROD_W-1:0]   prod_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam word_type ONE      = 32'sh0100_0000;
   localparam word_type TWO_PI   = 32'sd105414357;
   localparam word_type PI       = 32'sd52707179;
   localparam word_type HALF_PI  = 32'sd26353589;
   localparam cord_type GAIN     = 40'sd10188014;

   // Command codes
   typedef enum logic [1:0] {
      KIND_IDENTITY  = 2'd0,
      KIND_TRANSLATE = 2'd1,
      KIND_ROTATE    = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_FOLD,
      ST_CORDIC,
      ST_TRIG,
      ST_ROD_MUL,
      ST_ROD_ACC,
      ST_MAT_MUL,
      ST_MAT_ACC
   } state_type;

   // Micro-op fields for building the rotation matrix
   typedef enum logic [2:0] {OPD_X, OPD_Y, OPD_Z, OPD_VA, OPD_S, OPD_T0} opd_type;
   typedef enum logic [2:0] {ADD_NONE, ADD_C, ADD_XY, ADD_XZ, ADD_YZ} add_type;
   typedef enum logic [2:0] {DST_T0, DST_XY, DST_XZ, DST_YZ, DST_R} dst_type;

   typedef struct packed {
      opd_type    opd_a;
      opd_type    opd_b;
      add_type    add_sel;
      logic       sub;
      dst_type    dst;
      logic [3:0] r_idx;
   } rod_op_type;

   localparam logic [4:0] ROD_LAST = 5'd17;

   // Rodrigues program: R = c*I + (1-c)*a*a^T + s*[a]x
   function automatic rod_op_type rod_op(input logic [4:0] step);
      rod_op_type op;
      op = '{OPD_X, OPD_Y, ADD_NONE, 1'b0, DST_T0, 4'd0};
      unique case (step)
         5'd0:  op = '{OPD_X,  OPD_Y,  ADD_NONE, 1'b0, DST_T0, 4'd0};
         5'd1:  op = '{OPD_T0, OPD_VA, ADD_NONE, 1'b0, DST_XY, 4'd0};
         5'd2:  op = '{OPD_X,  OPD_Z,  ADD_NONE, 1'b0, DST_T0, 4'd0};
         5'd3:  op = '{OPD_T0, OPD_VA, ADD_NONE, 1'b0, DST_XZ, 4'd0};
         5'd4:  op = '{OPD_Y,  OPD_Z,  ADD_NONE, 1'b0, DST_T0, 4'd0};
         5'd5:  op = '{OPD_T0, OPD_VA, ADD_NONE, 1'b0, DST_YZ, 4'd0};
         5'd6:  op = '{OPD_X,  OPD_X,  ADD_NONE, 1'b0, DST_T0, 4'd0};
         5'd7:  op = '{OPD_T0, OPD_VA, ADD_C,    1'b0, DST_R,  4'd0};
         5'd8:  op = '{OPD_Y,  OPD_Y,  ADD_NONE, 1'b0, DST_T0, 4'd0};
         5'd9:  op = '{OPD_T0, OPD_VA, ADD_C,    1'b0, DST_R,  4'd4};
         5'd10: op = '{OPD_Z,  OPD_Z,  ADD_NONE, 1'b0, DST_T0, 4'd0};
         5'd11: op = '{OPD_T0, OPD_VA, ADD_C,    1'b0, DST_R,  4'd8};
         5'd12: op = '{OPD_Z,  OPD_S,  ADD_XY,   1'b1, DST_R,  4'd1};
         5'd13: op = '{OPD_Z,  OPD_S,  ADD_XY,   1'b0, DST_R,  4'd3};
         5'd14: op = '{OPD_Y,  OPD_S,  ADD_XZ,   1'b0, DST_R,  4'd2};
         5'd15: op = '{OPD_Y,  OPD_S,  ADD_XZ,   1'b1, DST_R,  4'd6};
         5'd16: op = '{OPD_X,  OPD_S,  ADD_YZ,   1'b1, DST_R,  4'd5};
         5'd17: op = '{OPD_X,  OPD_S,  ADD_YZ,   1'b0, DST_R,  4'd7};
         default: op = '{OPD_X, OPD_Y, ADD_NONE, 1'b0, DST_T0, 4'd0};
      endcase
      return op;
   endfunction

   // Rounded arctan(2^-i) in Q.24
   function automatic cord_type atan_step(input logic [4:0] idx);
      cord_type a;
      case (idx)
         5'd0:    a = 40'sd13176795;
         5'd1:    a = 40'sd7778716;
         5'd2:    a = 40'sd4110060;
         5'd3:    a = 40'sd2086331;
         5'd4:    a = 40'sd1047214;
         5'd5:    a = 40'sd524117;
         5'd6:    a = 40'sd262123;
         5'd7:    a = 40'sd131069;
         default: a = cord_type'(1) <<< (5'(FRAC_W) - idx);
      endcase
      return a;
   endfunction

   // Round magnitude to nearest (ties away from zero), then saturate
   function automatic word_type mul_round(input prod_type prod);
      logic                neg;
      logic [PROD_W-1:0]   mag;
      logic [PROD_W-1:0]   q;
      word_type            r;
      neg = prod[PROD_W-1];
      mag = neg ? PROD_W'(-prod) : PROD_W'(prod);
      q   = (mag + (PROD_W'(1) << (FRAC_W - 1))) >> FRAC_W;
      if (!neg) begin
         r = (q > PROD_W'(WORD_MAX)) ? WORD_MAX : WORD_W'(q);
      end else begin
         r = (q > (PROD_W'(1) << (WORD_W - 1))) ? WORD_MIN : WORD_W'(~q + PROD_W'(1));
      end
      return r;
   endfunction

   // Saturating a + b or a - b
   function automatic word_type sat_add(input word_type a, input word_type b,
                                        input logic sub);
      logic signed [WORD_W:0] s;
      word_type               r;
      s = sub ? ({a[WORD_W-1], a} - {b[WORD_W-1], b})
              : ({a[WORD_W-1], a} + {b[WORD_W-1], b});
      if (s[WORD_W] != s[WORD_W-1]) begin
         r = s[WORD_W] ? WORD_MIN : WORD_MAX;
      end else begin
         r = s[WORD_W-1:0];
      end
      return r;
   endfunction

   function automatic word_type sat_cord(input cord_type v);
      word_type r;
      if (v > cord_type'(WORD_MAX)) begin
         r = WORD_MAX;
      end else if (v < cord_type'(WORD_MIN)) begin
         r = WORD_MIN;
      end else begin
         r = WORD_W'(v);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rta_req_if.sv
`default_nettype none
interface rta_req_if;
   import rta_pkg::*;

   logic       valid;
   logic       ready;
   logic [1:0] kind;
   word_type   angle;
   word_type   vec_x;
   word_type   vec_y;
   word_type   vec_z;

   modport source (output valid, kind, angle, vec_x, vec_y, vec_z, input ready);
   modport sink   (input valid, kind, angle, vec_x, vec_y, vec_z, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rta_rsp_if.sv
`default_nettype none
interface rta_rsp_if;
   import rta_pkg::*;

   logic     valid;
   logic     ready;
   word_type rot_00, rot_01, rot_02, trans_0;
   word_type rot_10, rot_11, rot_12, trans_1;
   word_type rot_20, rot_21, rot_22, trans_2;

   modport source (output valid, rot_00, rot_01, rot_02, trans_0,
                   rot_10, rot_11, rot_12, trans_1,
                   rot_20, rot_21, rot_22, trans_2, input ready);
   modport sink   (input valid, rot_00, rot_01, rot_02, trans_0,
                   rot_10, rot_11, rot_12, trans_1,
                   rot_20, rot_21, rot_22, trans_2, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rigid_transform_accumulator_core.sv
`default_nettype none
// Keeps a 3x4 rigid transform in signed Q8.24 and applies one command per
// request: identity, translate (adds the offset to the translation column) or
// rotate (axis-angle rotation multiplied onto the right of the rotation part).
// Each request returns all twelve entries, row-major, read from the pose
// registers; a new request is taken only once the previous response is gone.
// Identity, translate and the unused code respond in the cycle after the
// request is taken. Rotate runs on one 32x32 multiplier: angle reduction by
// 2*pi, a fold step, 24 CORDIC iterations, a step for sine, cosine and
// 1-cos, 18 multiplies for the Rodrigues matrix and 27 multiply-adds for
// the 3x3 product.
module rigid_transform_accumulator_core (
   input  wire logic  clock,
   input  wire logic  reset,
   rta_req_if.sink    req_chan,
   rta_rsp_if.source  rsp_chan
);
   import rta_pkg::*;

   localparam logic [WORD_W-1:0] TWO_PI_U = WORD_W'(TWO_PI);

   state_type state_ff, state_in;

   logic              rsp_valid_ff;
   logic              req_ready;
   logic              req_accept;
   logic              mat_last;

   word_type          pose_ff [12];
   word_type          rmat_ff [9];
   word_type          newrow_ff [2];
   word_type          ax_ff, ay_ff, az_ff;
   word_type          c_ff, s_ff, va_ff;
   word_type          t0_ff, xy_ff, xz_ff, yz_ff, acc_ff;
   logic [WORD_W-1:0] rem_ff;
   logic              ang_neg_ff;
   logic              flip_ff;
   cord_type          cx_ff, cy_ff, cz_ff;
   logic [4:0]        iter_ff;
   logic [4:0]        step_ff;
   logic [1:0]        row_ff, col_ff, term_ff;
   prod_type          prod_ff;

   rod_op_type        op;
   word_type          mul_a, mul_b;
   prod_type          prod_in;
   word_type          mul_res;
   word_type          addend;
   word_type          rod_res;
   word_type          mat_res;

   // Control decode
   always_comb begin
      req_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
      req_accept = req_chan.valid && req_ready;
      mat_last   = (row_ff == 2'd2) && (col_ff == 2'd2) && (term_ff == 2'd2);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_chan.kind == KIND_ROTATE) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (iter_ff == 5'd0) state_in = ST_FOLD;
         end
         ST_FOLD:    state_in = ST_CORDIC;
         ST_CORDIC: begin
            if (iter_ff == 5'(CORDIC_STEPS - 1)) state_in = ST_TRIG;
         end
         ST_TRIG:    state_in = ST_ROD_MUL;
         ST_ROD_MUL: state_in = ST_ROD_ACC;
         ST_ROD_ACC: state_in = (step_ff == ROD_LAST) ? ST_MAT_MUL : ST_ROD_MUL;
         ST_MAT_MUL: state_in = ST_MAT_ACC;
         ST_MAT_ACC: state_in = mat_last ? ST_IDLE : ST_MAT_MUL;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Operand selection for the shared multiplier
   always_comb begin
      op    = rod_op(step_ff);
      mul_a = ax_ff;
      mul_b = ay_ff;
      if (state_ff == ST_MAT_MUL) begin
         mul_a = pose_ff[{row_ff, term_ff}];
         mul_b = rmat_ff[4'({term_ff, 1'b0}) + 4'(term_ff) + 4'(col_ff)];
      end else begin
         case (op.opd_a)
            OPD_X:   mul_a = ax_ff;
            OPD_Y:   mul_a = ay_ff;
            OPD_Z:   mul_a = az_ff;
            OPD_VA:  mul_a = va_ff;
            OPD_S:   mul_a = s_ff;
            OPD_T0:  mul_a = t0_ff;
            default: mul_a = ax_ff;
         endcase
         case (op.opd_b)
            OPD_X:   mul_b = ax_ff;
            OPD_Y:   mul_b = ay_ff;
            OPD_Z:   mul_b = az_ff;
            OPD_VA:  mul_b = va_ff;
            OPD_S:   mul_b = s_ff;
            OPD_T0:  mul_b = t0_ff;
            default: mul_b = ay_ff;
         endcase
      end
      prod_in = mul_a * mul_b;
   end

   // Round the registered product and combine with the addend
   always_comb begin
      mul_res = mul_round(prod_ff);
      case (op.add_sel)
         ADD_C:   addend = c_ff;
         ADD_XY:  addend = xy_ff;
         ADD_XZ:  addend = xz_ff;
         ADD_YZ:  addend = yz_ff;
         default: addend = '0;
      endcase
      rod_res = (op.add_sel == ADD_NONE) ? mul_res : sat_add(addend, mul_res, op.sub);
      mat_res = (term_ff == 2'd0) ? mul_res : sat_add(acc_ff, mul_res, 1'b0);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_accept && req_chan.kind != KIND_ROTATE) begin
            rsp_valid_ff <= 1'b1;
         end
         if (state_ff == ST_MAT_ACC && mat_last) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   // Pose registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 12; k++) begin
            pose_ff[k] <= (k == 0 || k == 5 || k == 10) ? ONE : '0;
         end
      end else if (req_accept) begin
         case (req_chan.kind)
            KIND_IDENTITY: begin
               for (int k = 0; k < 12; k++) begin
                  pose_ff[k] <= (k == 0 || k == 5 || k == 10) ? ONE : '0;
               end
            end
            KIND_TRANSLATE: begin
               pose_ff[3]  <= sat_add(pose_ff[3],  req_chan.vec_x, 1'b0);
               pose_ff[7]  <= sat_add(pose_ff[7],  req_chan.vec_y, 1'b0);
               pose_ff[11] <= sat_add(pose_ff[11], req_chan.vec_z, 1'b0);
            end
            default: begin
            end
         endcase
      end else if (state_ff == ST_MAT_ACC && term_ff == 2'd2 && col_ff == 2'd2) begin
         // commit the finished row
         pose_ff[{row_ff, 2'd0}] <= newrow_ff[0];
         pose_ff[{row_ff, 2'd1}] <= newrow_ff[1];
         pose_ff[{row_ff, 2'd2}] <= mat_res;
      end
   end

   // Rotate datapath
   always_ff @(posedge clock) begin
      logic [WORD_W-1:0]      sh;
      logic signed [WORD_W:0] zr;
      cord_type               xf, yf;
      word_type               cw;
      sh = TWO_PI_U << iter_ff;
      zr = '0;
      xf = '0;
      yf = '0;
      cw = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ang_neg_ff <= req_chan.angle[WORD_W-1];
               rem_ff     <= req_chan.angle[WORD_W-1] ? WORD_W'(-req_chan.angle)
                                                      : WORD_W'(req_chan.angle);
               ax_ff      <= req_chan.vec_x;
               ay_ff      <= req_chan.vec_y;
               az_ff      <= req_chan.vec_z;
               iter_ff    <= 5'd4;
            end
         end
         ST_REDUCE: begin
            // one restoring step of the remainder by 2*pi
            if (rem_ff >= sh) rem_ff <= rem_ff - sh;
            iter_ff <= iter_ff - 5'd1;
         end
         ST_FOLD: begin
            // bring the angle into [-pi/2, pi/2], remember the half turn
            zr = ang_neg_ff ? -$signed({1'b0, rem_ff}) : $signed({1'b0, rem_ff});
            if (zr > (WORD_W+1)'(PI)) zr = zr - (WORD_W+1)'(TWO_PI);
            else if (zr < -(WORD_W+1)'(PI)) zr = zr + (WORD_W+1)'(TWO_PI);
            flip_ff <= 1'b0;
            if (zr > (WORD_W+1)'(HALF_PI)) begin
               zr = zr - (WORD_W+1)'(PI);
               flip_ff <= 1'b1;
            end else if (zr < -(WORD_W+1)'(HALF_PI)) begin
               zr = zr + (WORD_W+1)'(PI);
               flip_ff <= 1'b1;
            end
            cz_ff   <= CORDIC_W'(zr);
            cx_ff   <= GAIN;
            cy_ff   <= '0;
            iter_ff <= '0;
         end
         ST_CORDIC: begin
            if (!cz_ff[CORDIC_W-1]) begin
               cx_ff <= cx_ff - (cy_ff >>> iter_ff);
               cy_ff <= cy_ff + (cx_ff >>> iter_ff);
               cz_ff <= cz_ff - atan_step(iter_ff);
            end else begin
               cx_ff <= cx_ff + (cy_ff >>> iter_ff);
               cy_ff <= cy_ff - (cx_ff >>> iter_ff);
               cz_ff <= cz_ff + atan_step(iter_ff);
            end
            iter_ff <= iter_ff + 5'd1;
         end
         ST_TRIG: begin
            xf = flip_ff ? -cx_ff : cx_ff;
            yf = flip_ff ? -cy_ff : cy_ff;
            cw = sat_cord(xf);
            c_ff    <= cw;
            s_ff    <= sat_cord(yf);
            va_ff   <= sat_add(ONE, cw, 1'b1);
            step_ff <= '0;
            row_ff  <= '0;
            col_ff  <= '0;
            term_ff <= '0;
         end
         ST_ROD_MUL, ST_MAT_MUL: begin
            prod_ff <= prod_in;
         end
         ST_ROD_ACC: begin
            case (op.dst)
               DST_T0:  t0_ff <= rod_res;
               DST_XY:  xy_ff <= rod_res;
               DST_XZ:  xz_ff <= rod_res;
               DST_YZ:  yz_ff <= rod_res;
               default: rmat_ff[op.r_idx] <= rod_res;
            endcase
            step_ff <= step_ff + 5'd1;
         end
         ST_MAT_ACC: begin
            acc_ff <= mat_res;
            if (term_ff == 2'd2) begin
               term_ff <= '0;
               if (col_ff == 2'd2) begin
                  col_ff <= '0;
                  row_ff <= row_ff + 2'd1;
               end else begin
                  newrow_ff[col_ff[0]] <= mat_res;
                  col_ff <= col_ff + 2'd1;
               end
            end else begin
               term_ff <= term_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // Ports
   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.rot_00  = pose_ff[0];
   assign rsp_chan.rot_01  = pose_ff[1];
   assign rsp_chan.rot_02  = pose_ff[2];
   assign rsp_chan.trans_0 = pose_ff[3];
   assign rsp_chan.rot_10  = pose_ff[4];
   assign rsp_chan.rot_11  = pose_ff[5];
   assign rsp_chan.rot_12  = pose_ff[6];
   assign rsp_chan.trans_1 = pose_ff[7];
   assign rsp_chan.rot_20  = pose_ff[8];
   assign rsp_chan.rot_21  = pose_ff[9];
   assign rsp_chan.rot_22  = pose_ff[10];
   assign rsp_chan.trans_2 = pose_ff[11];

   // Checks
   a_no_take_while_pending: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid_ff && req_ready))
      else $error("request taken while a response is pending");

   a_short_cmd_responds: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_chan.kind != KIND_ROTATE) |=> rsp_valid_ff)
      else $error("short command gave no response");

   a_rotate_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAT_ACC && mat_last) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("rotate did not finish with a response");

   a_cordic_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC) |-> (iter_ff < 5'(CORDIC_STEPS)))
      else $error("CORDIC iteration index out of range");

endmodule
`default_nettype wire

// File: tb/sv/rigid_transform_accumulator_core_test.sv
`default_nettype none
module rigid_transform_accumulator_core_test;
   import rta_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam longint     PI_Q61      = 64'h6487ED5110B4611A;
   localparam longint     GAIN_Q60    = 64'd700114967507363235;
   localparam longint     W_MAX       = 64'sd2147483647;
   localparam longint     W_MIN       = -64'sd2147483648;
   localparam longint     CYCLE_LIMIT = 2000000;
   localparam int         RAND_ITEMS  = 750;

   typedef logic [12*WORD_W-1:0] pose_flat_type;

   typedef struct {
      logic [1:0]    kind;
      word_type      angle;
      word_type      vx, vy, vz;
      bit            typed;
      pose_flat_type pose;
   } cmd_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rta_req_if req_chan ();
   rta_rsp_if rsp_chan ();

   rigid_transform_accumulator_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #10 clock = ~clock;

   longint        pose_model [12];
   pose_flat_type pose_queue [$];
   cmd_row_type   cmd_table [$];
   int            error_count = 0;
   longint        cycle_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   bit            typed_queue [$];
   pose_flat_type typed_pose_queue [$];

   // Fixed-point arithmetic of the pose datapath
   function automatic longint clamp_word(input longint v);
      if (v > W_MAX) return W_MAX;
      if (v < W_MIN) return W_MIN;
      return v;
   endfunction

   function automatic longint add_sat(input longint a, input longint b, input bit sub);
      return clamp_word(sub ? a - b : a + b);
   endfunction

   function automatic longint mul_q(input longint a, input longint b);
      longint p, m, q;
      bit     neg;
      p   = a * b;
      neg = p < 0;
      m   = neg ? -p : p;
      q   = (m + (64'sd1 << (FRAC_W - 1))) >>> FRAC_W;
      if (neg) begin
         if (q > 64'sd2147483648) q = 64'sd2147483648;
         return -q;
      end
      if (q > W_MAX) q = W_MAX;
      return q;
   endfunction

   function automatic longint round_down(input longint u, input int s);
      return (u >> s) + ((u >> (s - 1)) & 64'd1);
   endfunction

   function automatic longint arctan_q(input int i);
      longint acc;
      bit     plus;
      acc  = 0;
      plus = 1;
      if (i == 0) return round_down(PI_Q61, 63 - FRAC_W);
      for (int n = 1; n * i <= 62; n += 2) begin
         acc  = plus ? acc + ((64'sd1 << (62 - n * i)) / n)
                     : acc - ((64'sd1 << (62 - n * i)) / n);
         plus = !plus;
      end
      return round_down(acc, 62 - FRAC_W);
   endfunction

   // Reduce the angle, fold into the right half plane, then run the CORDIC
   task automatic cordic_trig(input longint angle, output longint c, output longint s);
      longint two_pi, pi_q, half_pi, x, y, z, dx, dy, a;
      bit     flip;
      two_pi  = round_down(PI_Q61, 60 - FRAC_W);
      pi_q    = round_down(PI_Q61, 61 - FRAC_W);
      half_pi = round_down(PI_Q61, 62 - FRAC_W);
      x       = round_down(GAIN_Q60, 60 - FRAC_W);
      y       = 0;
      flip    = 0;
      z       = angle % two_pi;
      if (z > pi_q) z -= two_pi;
      if (z < -pi_q) z += two_pi;
      if (z > half_pi) begin
         z -= pi_q;
         flip = 1;
      end else if (z < -half_pi) begin
         z += pi_q;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         a  = arctan_q(i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= a;
         end else begin
            x += dx; y -= dy; z += a;
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = clamp_word(x);
      s = clamp_word(y);
   endtask

   // Advance the pose by one command and return all twelve entries
   task automatic pose_advance(input logic [1:0] kind, input word_type angle,
                               input word_type vx, input word_type vy,
                               input word_type vz, output pose_flat_type flat);
      longint c, s, va, xy, xz, yz, x, y, z;
      longint r [3][3];
      longint row [3];
      x = vx; y = vy; z = vz;
      case (kind)
         KIND_IDENTITY: begin
            foreach (pose_model[k]) pose_model[k] = 0;
            pose_model[0] = 64'sd1 << FRAC_W;
            pose_model[5] = 64'sd1 << FRAC_W;
            pose_model[10] = 64'sd1 << FRAC_W;
         end
         KIND_TRANSLATE: begin
            pose_model[3]  = add_sat(pose_model[3], x, 0);
            pose_model[7]  = add_sat(pose_model[7], y, 0);
            pose_model[11] = add_sat(pose_model[11], z, 0);
         end
         KIND_ROTATE: begin
            cordic_trig(angle, c, s);
            va = add_sat(64'sd1 << FRAC_W, c, 1);
            xy = mul_q(mul_q(x, y), va);
            xz = mul_q(mul_q(x, z), va);
            yz = mul_q(mul_q(y, z), va);
            r[0][0] = add_sat(mul_q(mul_q(x, x), va), c, 0);
            r[0][1] = add_sat(xy, mul_q(z, s), 1);
            r[0][2] = add_sat(xz, mul_q(y, s), 0);
            r[1][0] = add_sat(xy, mul_q(z, s), 0);
            r[1][1] = add_sat(mul_q(mul_q(y, y), va), c, 0);
            r[1][2] = add_sat(yz, mul_q(x, s), 1);
            r[2][0] = add_sat(xz, mul_q(y, s), 1);
            r[2][1] = add_sat(yz, mul_q(x, s), 0);
            r[2][2] = add_sat(mul_q(mul_q(z, z), va), c, 0);
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 3; j++)
                  row[j] = add_sat(add_sat(mul_q(pose_model[i*4], r[0][j]),
                                           mul_q(pose_model[i*4+1], r[1][j]), 0),
                                   mul_q(pose_model[i*4+2], r[2][j]), 0);
               for (int j = 0; j < 3; j++) pose_model[i*4+j] = row[j];
            end
         end
         default: ;
      endcase
      for (int k = 0; k < 12; k++) flat[k*WORD_W +: WORD_W] = word_type'(pose_model[k]);
   endtask

   function automatic pose_flat_type pose_with_trans(input word_type t0, input word_type t1,
                                                     input word_type t2);
      pose_flat_type f;
      f = '0;
      f[0*WORD_W +: WORD_W]  = ONE;
      f[5*WORD_W +: WORD_W]  = ONE;
      f[10*WORD_W +: WORD_W] = ONE;
      f[3*WORD_W +: WORD_W]  = t0;
      f[7*WORD_W +: WORD_W]  = t1;
      f[11*WORD_W +: WORD_W] = t2;
      return f;
   endfunction

   task automatic add_cmd(input logic [1:0] kind, input word_type angle, input word_type vx,
                          input word_type vy, input word_type vz, input bit typed,
                          input pose_flat_type pose);
      cmd_row_type row;
      row = '{kind, angle, vx, vy, vz, typed, pose};
      cmd_table.push_back(row);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Hold the command on the channel until it is taken
   task automatic send_cmd(input cmd_row_type row);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      typed_queue.push_back(row.typed);
      typed_pose_queue.push_back(row.pose);
      req_chan.kind     <= row.kind;
      req_chan.angle    <= row.angle;
      req_chan.vec_x    <= row.vx;
      req_chan.vec_y    <= row.vy;
      req_chan.vec_z    <= row.vz;
      req_chan.valid    <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   function automatic word_type unit_part(input real p, input real n);
      return word_type'($rtoi(p / n * 16777216.0));
   endfunction

   function automatic real rand_unit();
      return real'(int'($urandom_range(2000)) - 1000) / 1000.0;
   endfunction

   // Build one random command; mostly valid rotations and small translations
   function automatic cmd_row_type random_cmd();
      cmd_row_type row;
      real         ax, ay, az, n;
      int          pick;
      pick      = $urandom_range(99);
      row.typed = 0;
      row.pose  = '0;
      row.angle = $urandom;
      row.vx    = $urandom;
      row.vy    = $urandom;
      row.vz    = $urandom;
      if (pick < 55) begin
         row.kind = KIND_ROTATE;
         ax = rand_unit(); ay = rand_unit(); az = rand_unit();
         n  = $sqrt(ax*ax + ay*ay + az*az);
         if (n < 0.001) begin
            ax = 1.0; n = 1.0;
         end
         row.vx = unit_part(ax, n);
         row.vy = unit_part(ay, n);
         row.vz = unit_part(az, n);
         if ($urandom_range(3) != 0) row.angle = word_type'(int'($urandom_range(210000000)) - 105000000);
      end else if (pick < 80) begin
         row.kind = KIND_TRANSLATE;
         if ($urandom_range(3) != 0) begin
            row.vx = word_type'(int'($urandom_range(400000000)) - 200000000);
            row.vy = word_type'(int'($urandom_range(400000000)) - 200000000);
            row.vz = word_type'(int'($urandom_range(400000000)) - 200000000);
         end
      end else if (pick < 88) begin
         row.kind = KIND_IDENTITY;
      end else if (pick < 94) begin
         row.kind = KIND_UNUSED;
      end else begin
         // broken axis: full-range garbage
         row.kind = KIND_ROTATE;
      end
      return row;
   endfunction

   // Predict at every accepted request
   always @(posedge clock) begin
      pose_flat_type pred;
      bit            typed;
      pose_flat_type typed_pose;
      if (!reset && req_chan.valid && req_chan.ready) begin
         pose_advance(req_chan.kind, req_chan.angle, req_chan.vec_x, req_chan.vec_y,
                      req_chan.vec_z, pred);
         typed      = typed_queue.pop_front();
         typed_pose = typed_pose_queue.pop_front();
         pose_queue.push_back(typed ? typed_pose : pred);
      end
   end

   // Stall the response side at random
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Compare every accepted response against the oldest prediction
   always @(posedge clock) begin
      pose_flat_type want;
      word_type      got [12];
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.rot_00, rsp_chan.rot_01, rsp_chan.rot_02, rsp_chan.trans_0,
                 rsp_chan.rot_10, rsp_chan.rot_11, rsp_chan.rot_12, rsp_chan.trans_1,
                 rsp_chan.rot_20, rsp_chan.rot_21, rsp_chan.rot_22, rsp_chan.trans_2};
         if (pose_queue.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = pose_queue.pop_front();
            for (int k = 0; k < 12; k++)
               if (got[k] !== word_type'(want[k*WORD_W +: WORD_W]))
                  report_mismatch($sformatf("entry %0d", k), got[k],
                                  word_type'(want[k*WORD_W +: WORD_W]));
         end
      end
   end

   // Drop out on a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      pose_flat_type ident;
      int            phase_idle [3];
      int            phase_stall [3];
      pose_advance(KIND_IDENTITY, 0, 0, 0, 0, ident);
      ident          = pose_with_trans(0, 0, 0);
      phase_idle     = '{27, 76, 0};
      phase_stall    = '{76, 27, 0};
      req_chan.valid = 1'b0;
      req_chan.kind  = KIND_IDENTITY;
      req_chan.angle = '0;
      req_chan.vec_x = '0;
      req_chan.vec_y = '0;
      req_chan.vec_z = '0;
      rsp_chan.ready = 1'b0;

      // Directed commands: extremes, every kind, degenerate axes
      add_cmd(KIND_IDENTITY, WORD_MAX, WORD_MIN, WORD_MAX, -1, 1, ident);
      add_cmd(KIND_UNUSED, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1, ident);
      add_cmd(KIND_TRANSLATE, WORD_MIN, WORD_MAX, WORD_MIN, 0, 1,
              pose_with_trans(WORD_MAX, WORD_MIN, 0));
      add_cmd(KIND_TRANSLATE, 0, 1, -1, ONE, 1, pose_with_trans(WORD_MAX, WORD_MIN, ONE));
      add_cmd(KIND_IDENTITY, 0, 0, 0, 0, 1, ident);
      add_cmd(KIND_ROTATE, 0, 0, 0, ONE, 0, '0);
      add_cmd(KIND_ROTATE, HALF_PI, ONE, 0, 0, 0, '0);
      add_cmd(KIND_ROTATE, PI, 0, ONE, 0, 0, '0);
      add_cmd(KIND_ROTATE, -PI, 0, 0, -ONE, 0, '0);
      add_cmd(KIND_ROTATE, TWO_PI, ONE, 0, 0, 0, '0);
      add_cmd(KIND_ROTATE, WORD_MAX, 0, ONE, 0, 0, '0);
      add_cmd(KIND_ROTATE, WORD_MIN, 0, 0, ONE, 0, '0);
      add_cmd(KIND_ROTATE, 32'sd20000000, 0, 0, 0, 0, '0);
      add_cmd(KIND_IDENTITY, 0, 0, 0, 0, 1, ident);
      add_cmd(KIND_ROTATE, 32'sd30000000, WORD_MAX, WORD_MAX, WORD_MIN, 0, '0);
      add_cmd(KIND_ROTATE, -32'sd40000000, WORD_MIN, WORD_MIN, WORD_MIN, 0, '0);
      add_cmd(KIND_TRANSLATE, 0, WORD_MIN, WORD_MIN, WORD_MIN, 0, '0);
      add_cmd(KIND_UNUSED, 0, 0, 0, 0, 0, '0);
      add_cmd(KIND_IDENTITY, 0, 0, 0, 0, 1, ident);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = phase_idle[0];
      recv_stall_pct = phase_stall[0];
      foreach (cmd_table[i]) send_cmd(cmd_table[i]);

      for (int p = 0; p < 3; p++) begin
         send_idle_pct  = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         for (int i = 0; i < RAND_ITEMS / 3; i++) begin
            // hold off until the pipe drains once per phase
            if (i == 100) begin
               req_chan.valid <= 1'b0;
               while (pose_queue.size() != 0) @(posedge clock);
               @(posedge clock);
            end
            send_cmd(random_cmd());
         end
      end
      req_chan.valid <= 1'b0;

      while (pose_queue.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
